// File: hw/rtl/rrs_pkg.sv
// Package: shared types, widths and constants for the record replay smoother.
package rrs_pkg;

    // Field widths
    localparam int COUNT_W = 32;
    localparam int POS_W   = 32;
    localparam int Y_W     = 11;
    localparam int DROP_W  = 7;

    // Default replay queue depth
    localparam int QUEUE_DEPTH_DEF = 64;

    // Blend arithmetic: h0 + 2h1 + 3h2 + 4h3 + 10p fits in 37 bits signed
    localparam int SUM_W   = 37;
    localparam int MAG_W   = 15;          // |sum| below the clamp limit
    localparam int RECIP_W = 16;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_20 = 16'd52429;   // ceil(2^20 / 20)

    // sum >= 20020 gives y > 1000, sum <= -20020 gives y < -1000
    localparam logic signed [SUM_W-1:0] SUM_HI = 37'sd20020;
    localparam logic signed [SUM_W-1:0] SUM_LO = -37'sd20020;
    localparam logic signed [Y_W-1:0]   Y_MAX  = 11'sd1000;
    localparam logic signed [Y_W-1:0]   Y_MIN  = -11'sd1000;

    localparam logic [DROP_W-1:0] DROP_MAX = 7'd127;

    // Command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [COUNT_W-1:0]      count;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_CHECK,
        S_READ,
        S_WAIT,
        S_OUT
    } t_state;

endpackage

// File: hw/rtl/rrs_queue.sv
// Replay queue: record memory with registered read, pointers and occupancy.
module rrs_queue #(
    parameter int DEPTH = rrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rrs_pkg::t_rec     i_wr_rec,
    input  logic              i_pop,
    output rrs_pkg::t_rec     o_rd_rec,
    output rrs_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    rrs_pkg::t_rec    r_mem [DEPTH];
    rrs_pkg::t_rec    r_rd_data;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [OCC_W-1:0] r_occ;

    // storage: no reset, entries are read only once written
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_occ <= r_occ + OCC_W'(1);
                2'b01:   r_occ <= r_occ - OCC_W'(1);
                default: r_occ <= r_occ;
            endcase
        end
    end

    assign o_rd_rec       = r_rd_data;
    assign o_status.full  = (r_occ == OCC_FULL);
    assign o_status.empty = (r_occ == '0);

endmodule

// File: hw/rtl/rrs_blend.sv
// Smoothing filter: weighted sum with output history, divide by 20, clamp.
module rrs_blend (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [rrs_pkg::POS_W-1:0] i_pos,
    output logic                             o_done,
    output logic signed [rrs_pkg::Y_W-1:0]   o_y
);

    localparam int SW = rrs_pkg::SUM_W;

    logic signed [rrs_pkg::Y_W-1:0] r_hist [4];
    logic signed [SW-1:0]           r_sum;
    logic                           r_v1;
    logic                           r_done;
    logic signed [rrs_pkg::Y_W-1:0] r_y;

    logic signed [SW-1:0]               c_h0, c_h1, c_h2, c_h3, c_p, c_sum;
    logic                               c_hi, c_lo, c_neg;
    logic signed [SW-1:0]               c_abs;
    logic [rrs_pkg::MAG_W-1:0]          c_mag;
    logic [rrs_pkg::PROD_W-1:0]         c_prod;
    logic signed [rrs_pkg::Y_W-1:0]     c_q, c_y;

    // stage 1: weighted sum
    always_comb begin
        c_h0  = SW'(r_hist[0]);
        c_h1  = SW'(r_hist[1]);
        c_h2  = SW'(r_hist[2]);
        c_h3  = SW'(r_hist[3]);
        c_p   = SW'(i_pos);
        c_sum = c_h0 + (c_h1 <<< 1) + c_h2 + (c_h2 <<< 1) + (c_h3 <<< 2)
              + (c_p <<< 3) + (c_p <<< 1);
    end

    // stage 2: clamp decision, then |sum| / 20 by reciprocal (exact below 2^15)
    always_comb begin
        c_hi   = (r_sum >= rrs_pkg::SUM_HI);
        c_lo   = (r_sum <= rrs_pkg::SUM_LO);
        c_neg  = r_sum[SW-1];
        c_abs  = c_neg ? -r_sum : r_sum;
        c_mag  = c_abs[rrs_pkg::MAG_W-1:0];
        c_prod = rrs_pkg::PROD_W'(c_mag) * rrs_pkg::PROD_W'(rrs_pkg::RECIP_20);
        c_q    = $signed(c_prod[rrs_pkg::RECIP_SHIFT +: rrs_pkg::Y_W]);
        if (c_hi) begin
            c_y = rrs_pkg::Y_MAX;
        end else if (c_lo) begin
            c_y = rrs_pkg::Y_MIN;
        end else begin
            c_y = c_neg ? -c_q : c_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= c_sum;
        end
        if (r_v1) begin
            r_y <= c_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
            if (r_v1) begin
                r_hist[0] <= r_hist[1];
                r_hist[1] <= r_hist[2];
                r_hist[2] <= r_hist[3];
                r_hist[3] <= c_y;
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

// File: hw/rtl/record_replay_smoother_top.sv
// Top level: record replay queue feeding a smoothing filter, stream in and out.
//
//  channel   | dir | fields (tdata / tuser, lowest bit first)
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | tdata: count[31:0], position[63:32]; tuser: command
//  m_axis    | out | tdata: smoothed[10:0], dropped[17:11], zero[23:18];
//            |     | tuser: accepted[0], stop[1]
//
// One transaction in at a time. A push goes through the push and output states
// before the next input is taken. A query pops records while the requested
// count is beyond the current record and the queue is not empty, each pop
// being a read of the record memory and a compare of the current record;
// then the blend runs and its result goes to the output state.
// The blend is pipelined: the sum is registered, then the divide and clamp.
// i_rst_n is synchronous, active low; the record memory itself is not cleared.
// A stalled m_axis holds its transaction; a result finished behind it waits
// in the FSM, and s_axis_tready stays low until the FSM is idle again.
module record_replay_smoother_top #(
    parameter int QUEUE_DEPTH = rrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // count[31:0], position[63:32]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // smoothed[10:0], dropped[17:11], zero
    output logic [1:0]  m_axis_tuser    // accepted[0], stop[1]
);

    rrs_pkg::t_state   r_state, n_state;

    // latched input transaction
    logic [rrs_pkg::COUNT_W-1:0]           r_cnt;
    logic signed [rrs_pkg::POS_W-1:0]      r_pos;

    // replay state kept outside the memory
    rrs_pkg::t_rec                         r_cur;
    logic                                  r_stop;
    logic [rrs_pkg::DROP_W-1:0]            r_drop;

    // pending result
    logic                                  r_res_acc;
    logic signed [rrs_pkg::Y_W-1:0]        r_res_y;

    // output register
    logic                                  r_m_valid;
    logic [23:0]                           r_m_data;
    logic [1:0]                            r_m_user;

    // control
    logic                                  c_in_acc;
    logic                                  c_q_push;
    logic                                  c_q_pop;
    logic                                  c_blend_go;
    logic                                  c_set_stop;
    logic                                  c_load_cur;
    logic                                  c_load_out;
    logic                                  c_out_free;
    logic                                  c_more;

    rrs_pkg::t_rec                         c_wr_rec;
    rrs_pkg::t_rec                         q_rd_rec;
    rrs_pkg::t_q_status                    q_status;
    logic                                  b_done;
    logic signed [rrs_pkg::Y_W-1:0]        b_y;

    assign c_in_acc   = s_axis_tvalid && s_axis_tready;
    assign c_out_free = !r_m_valid || m_axis_tready;
    assign c_more     = (r_cnt > r_cur.count);

    assign c_wr_rec.count    = r_cnt;
    assign c_wr_rec.position = r_pos;

    rrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (c_q_push),
        .i_wr_rec (c_wr_rec),
        .i_pop    (c_q_pop),
        .o_rd_rec (q_rd_rec),
        .o_status (q_status)
    );

    rrs_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_blend_go),
        .i_pos   (r_cur.position),
        .o_done  (b_done),
        .o_y     (b_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and per-state control
    always_comb begin
        n_state    = r_state;
        c_q_push   = 1'b0;
        c_q_pop    = 1'b0;
        c_blend_go = 1'b0;
        c_set_stop = 1'b0;
        c_load_cur = 1'b0;
        c_load_out = 1'b0;
        case (r_state)
            rrs_pkg::S_IDLE: begin
                if (c_in_acc) begin
                    n_state = (s_axis_tuser[0] == rrs_pkg::CMD_PUSH) ?
                              rrs_pkg::S_PUSH : rrs_pkg::S_CHECK;
                end
            end
            rrs_pkg::S_PUSH: begin
                // full queue: record rejected, stop latched
                c_q_push   = !q_status.full;
                c_set_stop = q_status.full;
                n_state    = rrs_pkg::S_OUT;
            end
            rrs_pkg::S_CHECK: begin
                if (c_more && !q_status.empty) begin
                    c_q_pop = 1'b1;
                    n_state = rrs_pkg::S_READ;
                end else begin
                    // caught up or ran dry: blend; if still behind, keep last record and stop
                    c_set_stop = c_more;
                    c_blend_go = 1'b1;
                    n_state    = rrs_pkg::S_WAIT;
                end
            end
            rrs_pkg::S_READ: begin
                c_load_cur = 1'b1;
                n_state    = rrs_pkg::S_CHECK;
            end
            rrs_pkg::S_WAIT: begin
                if (b_done) begin
                    n_state = rrs_pkg::S_OUT;
                end
            end
            rrs_pkg::S_OUT: begin
                if (c_out_free) begin
                    c_load_out = 1'b1;
                    n_state    = rrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrs_pkg::S_IDLE;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (c_in_acc) begin
            r_cnt   <= s_axis_tdata[31:0];
            r_pos   <= $signed(s_axis_tdata[63:32]);
            r_res_y <= '0;
        end
        if (r_state == rrs_pkg::S_PUSH) begin
            r_res_acc <= !q_status.full;
        end else if (c_in_acc) begin
            r_res_acc <= 1'b1;
        end
        if (b_done && r_state == rrs_pkg::S_WAIT) begin
            r_res_y <= b_y;
        end
        if (c_load_out) begin
            r_m_data <= {6'd0, r_drop, r_res_y};
            r_m_user <= {r_stop, r_res_acc};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_stop    <= 1'b0;
            r_drop    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (c_load_cur) begin
                r_cur <= q_rd_rec;
            end
            if (c_set_stop) begin
                r_stop <= 1'b1;
            end
            if (c_in_acc) begin
                r_drop <= '0;
            end else if (c_q_pop && r_drop != rrs_pkg::DROP_MAX) begin
                r_drop <= r_drop + rrs_pkg::DROP_W'(1);
            end
            if (c_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == rrs_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// File: hw/rtl/rrs_checker.sv
// Port-level checker for the record replay smoother, bound to the top level.
module rrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // output is empty straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("m_axis transaction changed under stall");

    // a rejected push always reports stop
    a_reject_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("rejected push without stop");

    // smoothed value within clamp range
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[10:0]) <= rrs_pkg::Y_MAX) &&
            ($signed(m_axis_tdata[10:0]) >= rrs_pkg::Y_MIN))
        else $error("smoothed out of range");

    // one transaction at a time: no new input in the cycle after one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

endmodule

bind record_replay_smoother_top rrs_checker u_rrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/record_replay_smoother_checker.sv
// Checker: watches both stream channels, predicts each result and compares it.
module record_replay_smoother_checker #(
    parameter int DEPTH = rrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // count[31:0], position[63:32]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // smoothed[10:0], dropped[17:11], zero
    input  logic [1:0]  m_axis_tuser,   // accepted[0], stop[1]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic                           accepted;
        logic                           stop;
        logic signed [rrs_pkg::Y_W-1:0] smoothed;
        logic [rrs_pkg::DROP_W-1:0]     dropped;
    } t_result;

    rrs_pkg::t_rec                  rec_mem [DEPTH];
    int                             rd_ptr;
    int                             wr_ptr;
    int                             fill;
    rrs_pkg::t_rec                  cur_rec;
    logic signed [rrs_pkg::Y_W-1:0] hist [4];
    logic                           stop_seen;
    t_result                        expected_results [$];
    int                             mismatches = 0;

    // Model of one transaction into the block
    task automatic predict_step(input logic cmd,
                                input logic [rrs_pkg::COUNT_W-1:0] cnt,
                                input logic signed [rrs_pkg::POS_W-1:0] pos);
        t_result     res;
        int unsigned popped;
        longint      acc;
        longint      y;
        res = '0;
        res.accepted = 1'b1;
        if (cmd == rrs_pkg::CMD_PUSH) begin
            if (fill >= DEPTH) begin
                res.accepted = 1'b0;
                stop_seen = 1'b1;
            end else begin
                rec_mem[wr_ptr].count = cnt;
                rec_mem[wr_ptr].position = pos;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                fill++;
            end
        end else begin
            popped = 0;
            while (cnt > cur_rec.count) begin
                if (fill == 0) begin
                    stop_seen = 1'b1;
                    break;
                end
                cur_rec = rec_mem[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
                fill--;
                popped++;
            end
            acc = longint'(hist[0]) + 2 * longint'(hist[1]) + 3 * longint'(hist[2])
                + 4 * longint'(hist[3]) + 10 * longint'(cur_rec.position);
            y = acc / 20;
            if (y > 1000)
                y = 1000;
            if (y < -1000)
                y = -1000;
            hist[0] = hist[1];
            hist[1] = hist[2];
            hist[2] = hist[3];
            hist[3] = y[rrs_pkg::Y_W-1:0];
            res.smoothed = y[rrs_pkg::Y_W-1:0];
            res.dropped = (popped > 127) ? rrs_pkg::DROP_MAX
                                         : popped[rrs_pkg::DROP_W-1:0];
        end
        res.stop = stop_seen;
        expected_results.push_back(res);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            cur_rec = '0;
            for (int i = 0; i < 4; i++)
                hist[i] = '0;
            stop_seen = 1'b0;
            expected_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_step(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, m_axis_tuser[0]);
                    check_field("stop", want.stop, m_axis_tuser[1]);
                    check_field("smoothed", int'(want.smoothed),
                                int'($signed(m_axis_tdata[10:0])));
                    check_field("dropped", want.dropped, m_axis_tdata[17:11]);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_results.size();
    end

endmodule

// File: tb/record_replay_smoother_top_test.sv
// Testbench top: clock, reset, stimulus and verdict for the record replay smoother.
module record_replay_smoother_top_test;

    localparam int ITEMS      = 450;
    localparam int CALM_AFTER = 390;    // no idling on either side from here on
    localparam int HOLD_AT    = 150;    // long receiver hold-off starts here
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 200;    // beyond the worst query latency

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;          // count[31:0], position[63:32]
    logic [0:0]  s_axis_tuser;          // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;          // smoothed[10:0], dropped[17:11], zero
    logic [1:0]  m_axis_tuser;          // accepted[0], stop[1]

    int          fail_count;
    int          pending;

    // Stimulus bookkeeping shared with the receiver process
    int          items_sent = 0;
    bit          calm = 1'b0;
    bit          long_hold_done = 1'b0;
    logic [31:0] push_cursor;           // count of the latest well-ordered push

    record_replay_smoother_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    record_replay_smoother_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: far above the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one transaction: optional idle burst first, then hold it until taken.
    // tvalid stays high between back-to-back transactions.
    task automatic send_item(input logic cmd, input logic [31:0] cnt, input logic [31:0] pos);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, cnt};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic push_rec(input logic [31:0] cnt, input logic [31:0] pos);
        send_item(rrs_pkg::CMD_PUSH, cnt, pos);
    endtask

    // Position field is don't-care on a query, so it gets noise
    task automatic query_at(input logic [31:0] cnt);
        send_item(rrs_pkg::CMD_QUERY, cnt, $urandom);
    endtask

    // Mostly moderate positions, from -3000 to 3000, now and
    // then a full-range one
    function automatic logic [31:0] track_pos();
        int p;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        p = int'($urandom_range(0, 6000)) - 3000;
        return p;
    endfunction

    // A burst of ordered pushes, then a few queries walking up through them,
    // so each query typically consumes one or two records
    task automatic replay_burst();
        int unsigned n_push;
        int unsigned n_query;
        logic [31:0] first_c;
        logic [31:0] q;
        n_push  = $urandom_range(1, 6);
        n_query = $urandom_range(1, 3);
        first_c = push_cursor + 1;
        for (int i = 0; i < n_push; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_cursor += $urandom_range(1, 1 << 24);
            else
                push_cursor += $urandom_range(1, 40);
            if (i == 0)
                first_c = push_cursor;
            push_rec(push_cursor, track_pos());
        end
        for (int j = 1; j <= n_query; j++) begin
            q = first_c + (push_cursor - first_c) / n_query * j;
            if (j == n_query)
                q = push_cursor + $urandom_range(0, 5);
            else
                q += $urandom_range(0, 3);
            query_at(q);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off so the block backs up
    // onto its input, and always ready once the run goes calm
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && items_sent >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < 10) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        bit          overflow_done;
        int unsigned sel;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_rst_n       = 1'b0;
        overflow_done = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        query_at(32'd0);                    // nothing ahead of the dummy record
        push_rec(32'd10, 32'd2000);
        push_rec(32'd20, -32'sd2000);
        push_rec(32'd30, 32'h7FFF_FFFF);    // largest position
        push_rec(32'd40, 32'h8000_0000);    // smallest position
        push_rec(32'd50, 32'd600);
        push_rec(32'd0, 32'hFFFF_FFFF);     // out-of-order record, position -1
        query_at(32'd5);                    // one record consumed
        query_at(32'd10);                   // count equal to current: no pop
        query_at(32'd25);                   // two records consumed
        query_at(32'd40);                   // blend clamps low
        query_at(32'd45);
        query_at(32'd55);                   // queue runs empty: stop goes up
        query_at(32'hFFFF_FFFF);            // largest count on an empty queue
        push_rec(32'd100, 32'd1500);
        query_at(32'd100);
        query_at(32'd100);                  // history climbs towards the upper clamp
        query_at(32'd100);
        query_at(32'd100);
        push_rec(32'd110, 32'h7FFF_FFFF);
        query_at(32'd110);                  // blend clamps high
        push_cursor = 32'd200;

        // --- random part ---
        while (items_sent < ITEMS) begin
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
            sel = $urandom_range(0, 99);
            if (!overflow_done && items_sent >= 250) begin
                // fill the queue past its depth: late pushes are refused
                for (int i = 0; i < rrs_pkg::QUEUE_DEPTH_DEF + 6; i++) begin
                    push_cursor += $urandom_range(1, 20);
                    push_rec(push_cursor, track_pos());
                end
                overflow_done = 1'b1;
            end else if (sel < 68) begin
                replay_burst();
            end else if (sel < 82) begin
                // query beyond every stored record: drains the queue
                query_at(push_cursor + $urandom_range(1, 100));
            end else if ($urandom_range(0, 1) == 0) begin
                // unordered record with arbitrary content
                push_rec($urandom_range(0, push_cursor), $urandom);
            end else begin
                query_at($urandom);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Let every expected result come back, then watch for strays
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_queue.sv
hw/rtl/rrs_blend.sv
hw/rtl/record_replay_smoother_top.sv
hw/rtl/rrs_checker.sv
tb/record_replay_smoother_checker.sv
tb/record_replay_smoother_top_test.sv
